### rtl/tpc_pkg.sv
package tpc_pkg;

  // Default coordinate width, signed fixed point
  localparam int COORD_BITS_DEF = 32;

  // Bits of the crossing factor t, unsigned Q0.T_BITS
  localparam int T_BITS = 32;

  // Width of the color and glyph attributes
  localparam int ATTR_BITS = 16;

  // Depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_X  = 3'd0,
    CFG_POINT_Y  = 3'd1,
    CFG_POINT_Z  = 3'd2,
    CFG_NORMAL_X = 3'd3,
    CFG_NORMAL_Y = 3'd4,
    CFG_NORMAL_Z = 3'd5
  } cfg_idx_t;

  // Reset values of the nonzero plane registers
  localparam int POINT_Z_RST  = 6554;
  localparam int NORMAL_Z_RST = 65536;

  // Classification of a triangle against the plane
  typedef enum logic [1:0] {
    MODE_ONE = 2'd0,
    MODE_TWO = 2'd1,
    MODE_ALL = 2'd2
  } clip_mode_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_DIV   = 3'd1,
    BK_MUL   = 3'd2,
    BK_SUM   = 3'd3,
    BK_EMIT0 = 3'd4,
    BK_EMIT1 = 3'd5
  } back_state_t;

endpackage

### rtl/tpc_fifo.sv
module tpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tpc_pkg::QDEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       is_empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign rd_data  = mem_r[rd_ptr_r];
  assign is_empty = (count_r == '0);
  assign level    = count_r;

  // Store on write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/tpc_front.sv
module tpc_front #(
  parameter int COORD_BITS = tpc_pkg::COORD_BITS_DEF,
  localparam int DW      = 2 * COORD_BITS + 3,
  localparam int ENTRY_W = 2 + 2 * tpc_pkg::ATTR_BITS + 9 * COORD_BITS + 3 * DW
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic [2:0][2:0][COORD_BITS-1:0]       in_vtx,
  input  logic [tpc_pkg::ATTR_BITS-1:0]         in_color,
  input  logic [tpc_pkg::ATTR_BITS-1:0]         in_glyph,
  input  logic [2:0][COORD_BITS-1:0]            plane_pt,
  input  logic [2:0][COORD_BITS-1:0]            plane_nrm,
  input  logic [tpc_pkg::QCNT_W-1:0]            q_level,
  output logic                                  q_push,
  output logic [ENTRY_W-1:0]                    q_entry
);

  localparam int C = COORD_BITS;

  logic accept;

  // Stage 1: vertex minus plane point
  logic                                  s1_v_r;
  logic [2:0][2:0][C-1:0]                s1_vtx_r;
  logic [tpc_pkg::ATTR_BITS-1:0]         s1_color_r, s1_glyph_r;
  logic signed [C:0]                     s1_diff_r   [3][3];
  logic signed [C:0]                     s1_diff_nxt [3][3];

  // Stage 2: products with the normal
  logic                                  s2_v_r;
  logic [2:0][2:0][C-1:0]                s2_vtx_r;
  logic [tpc_pkg::ATTR_BITS-1:0]         s2_color_r, s2_glyph_r;
  logic signed [2*C:0]                   s2_prod_r   [3][3];
  logic signed [2*C:0]                   s2_prod_nxt [3][3];

  // Classification
  logic signed [DW-1:0]                  vdist  [3];
  logic [2:0]                            is_in;
  logic [1:0]                            perm   [3];
  logic [1:0]                            nin;
  tpc_pkg::clip_mode_t                   mode;
  logic [2:0][2:0][C-1:0]                u_vtx;
  logic [2:0][DW-1:0]                    u_dist;
  logic [tpc_pkg::QCNT_W:0]              credit;

  assign accept = push && !full;

  // Hold back input while in-flight items could overrun the queue
  assign credit = {1'b0, q_level} + (tpc_pkg::QCNT_W+1)'(s1_v_r)
                + (tpc_pkg::QCNT_W+1)'(s2_v_r);
  assign full   = (credit >= (tpc_pkg::QCNT_W+1)'(tpc_pkg::QDEPTH));

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        s1_diff_nxt[j][k] = $signed({in_vtx[j][k][C-1], in_vtx[j][k]})
                          - $signed({plane_pt[k][C-1], plane_pt[k]});
        s2_prod_nxt[j][k] = $signed(plane_nrm[k]) * s1_diff_r[j][k];
      end
    end
  end

  // Advance the distance pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vtx_r   <= in_vtx;
      s1_color_r <= in_color;
      s1_glyph_r <= in_glyph;
      s1_diff_r  <= s1_diff_nxt;
    end
    if (s1_v_r) begin
      s2_vtx_r   <= s1_vtx_r;
      s2_color_r <= s1_color_r;
      s2_glyph_r <= s1_glyph_r;
      s2_prod_r  <= s2_prod_nxt;
    end
  end

  // Sum distances and sort vertices: inside first, then outside
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      vdist[j] = s2_prod_r[j][0] + s2_prod_r[j][1] + s2_prod_r[j][2];
      is_in[j] = ~vdist[j][DW-1];
      perm[j]  = 2'd0;
    end
    nin = 2'd0;
    for (int j = 0; j < 3; j++) begin
      if (is_in[j]) begin
        perm[nin] = 2'(j);
        nin       = nin + 2'd1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (!is_in[j]) begin
        perm[nin] = 2'(j);
        nin       = nin + 2'd1;
      end
    end
    nin = 2'(is_in[0]) + 2'(is_in[1]) + 2'(is_in[2]);
    for (int m = 0; m < 3; m++) begin
      u_vtx[m]  = s2_vtx_r[perm[m]];
      u_dist[m] = vdist[perm[m]];
    end
  end

  always_comb begin
    unique case (nin)
      2'd1:    mode = tpc_pkg::MODE_ONE;
      2'd2:    mode = tpc_pkg::MODE_TWO;
      default: mode = tpc_pkg::MODE_ALL;
    endcase
  end

  // Drop triangles that are wholly outside
  assign q_push  = s2_v_r && (nin != 2'd0);
  assign q_entry = {mode, s2_color_r, s2_glyph_r, u_vtx, u_dist};

endmodule

### rtl/tpc_back.sv
module tpc_back #(
  parameter int COORD_BITS = tpc_pkg::COORD_BITS_DEF,
  localparam int DW      = 2 * COORD_BITS + 3,
  localparam int ENTRY_W = 2 + 2 * tpc_pkg::ATTR_BITS + 9 * COORD_BITS + 3 * DW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic [ENTRY_W-1:0]                q_entry,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_pop,
  output logic [2:0][2:0][COORD_BITS-1:0]   out_vtx,
  output logic [tpc_pkg::ATTR_BITS-1:0]     out_color,
  output logic [tpc_pkg::ATTR_BITS-1:0]     out_glyph,
  output logic                              out_last
);

  localparam int C     = COORD_BITS;
  localparam int T     = tpc_pkg::T_BITS;
  localparam int PW    = C + T + 2;
  localparam int CNT_W = $clog2(T);
  localparam logic signed [PW-1:0] HALF = PW'(1) << (T - 1);

  // Queue head fields
  logic [1:0]                       e_mode_bits;
  tpc_pkg::clip_mode_t              e_mode;
  logic [tpc_pkg::ATTR_BITS-1:0]    e_color, e_glyph;
  logic [2:0][2:0][C-1:0]           e_vtx;
  logic [2:0][DW-1:0]               e_dist;
  logic [1:0]                       e_b0, e_a1;

  assign {e_mode_bits, e_color, e_glyph, e_vtx, e_dist} = q_entry;
  assign e_mode = tpc_pkg::clip_mode_t'(e_mode_bits);
  // One inside: crossings u0-u1 and u0-u2. Two inside: u0-u2 and u1-u2.
  assign e_b0 = (e_mode == tpc_pkg::MODE_TWO) ? 2'd2 : 2'd1;
  assign e_a1 = (e_mode == tpc_pkg::MODE_TWO) ? 2'd1 : 2'd0;

  tpc_pkg::back_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r;
  tpc_pkg::clip_mode_t              mode_r;
  logic [tpc_pkg::ATTR_BITS-1:0]    color_r, glyph_r;
  logic [2:0][2:0][C-1:0]           vtx_r;
  logic [1:0][2:0][C-1:0]           base_r;
  logic signed [C:0]                delta_r [2][3];
  logic [DW:0]                      den_r   [2];
  logic [DW:0]                      rem_r   [2];
  logic [T-1:0]                     t_r     [2];
  logic signed [PW-1:0]             prod_r  [2][3];
  logic [1:0][2:0][C-1:0]           xv_r;

  logic                             room, out_load;
  logic [2:0][2:0][C-1:0]           tri_nxt;
  logic                             last_nxt;

  logic [DW+1:0]                    r2      [2];
  logic [DW+1:0]                    rsub    [2];
  logic                             ge      [2];
  logic signed [PW-1:0]             prod_nxt [2][3];
  logic [1:0][2:0][C-1:0]           xv_nxt;

  logic signed [PW-1:0]             rnd;
  logic signed [C+1:0]              sum;

  assign room = !out_valid || out_pop;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (e_mode == tpc_pkg::MODE_ALL) ? tpc_pkg::BK_EMIT1 : tpc_pkg::BK_DIV;
        end
      end
      tpc_pkg::BK_DIV: begin
        if (cnt_r == CNT_W'(T - 1)) begin
          state_nxt = tpc_pkg::BK_MUL;
        end
      end
      tpc_pkg::BK_MUL: state_nxt = tpc_pkg::BK_SUM;
      tpc_pkg::BK_SUM: begin
        state_nxt = (mode_r == tpc_pkg::MODE_TWO) ? tpc_pkg::BK_EMIT0 : tpc_pkg::BK_EMIT1;
      end
      tpc_pkg::BK_EMIT0: begin
        if (room) begin
          state_nxt = tpc_pkg::BK_EMIT1;
        end
      end
      tpc_pkg::BK_EMIT1: begin
        if (room) begin
          state_nxt = tpc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tpc_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      tpc_pkg::BK_IDLE:  q_pop    = !q_empty;
      tpc_pkg::BK_EMIT0: out_load = room;
      tpc_pkg::BK_EMIT1: out_load = room;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpc_pkg::BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == tpc_pkg::BK_DIV) ? cnt_r + 1'b1 : '0;
    end
  end

  // Restoring divide step and interpolation arithmetic
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      r2[c]   = {rem_r[c], 1'b0};
      rsub[c] = r2[c] - {1'b0, den_r[c]};
      ge[c]   = (r2[c] >= {1'b0, den_r[c]});
      for (int k = 0; k < 3; k++) begin
        prod_nxt[c][k] = delta_r[c][k] * $signed({1'b0, t_r[c]});
      end
    end
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < 3; k++) begin
        rnd = (prod_r[c][k] + HALF) >>> T;
        sum = $signed({{2{base_r[c][k][C-1]}}, base_r[c][k]}) + rnd[C+1:0];
        if (sum[C+1:C-1] == 3'b000 || sum[C+1:C-1] == 3'b111) begin
          xv_nxt[c][k] = sum[C-1:0];
        end else begin
          xv_nxt[c][k] = sum[C+1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end
      end
    end
  end

  // Load item, iterate divider, multiply, add
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mode_r    <= e_mode;
      color_r   <= e_color;
      glyph_r   <= e_glyph;
      vtx_r     <= e_vtx;
      base_r[0] <= e_vtx[0];
      base_r[1] <= e_vtx[e_a1];
      for (int k = 0; k < 3; k++) begin
        delta_r[0][k] <= $signed({e_vtx[e_b0][k][C-1], e_vtx[e_b0][k]})
                       - $signed({e_vtx[0][k][C-1], e_vtx[0][k]});
        delta_r[1][k] <= $signed({e_vtx[2][k][C-1], e_vtx[2][k]})
                       - $signed({e_vtx[e_a1][k][C-1], e_vtx[e_a1][k]});
      end
      den_r[0] <= {e_dist[0][DW-1], e_dist[0]} - {e_dist[e_b0][DW-1], e_dist[e_b0]};
      den_r[1] <= {e_dist[e_a1][DW-1], e_dist[e_a1]} - {e_dist[2][DW-1], e_dist[2]};
      rem_r[0] <= {1'b0, e_dist[0]};
      rem_r[1] <= {1'b0, e_dist[e_a1]};
    end
    if (state_r == tpc_pkg::BK_DIV) begin
      for (int c = 0; c < 2; c++) begin
        rem_r[c] <= ge[c] ? rsub[c][DW:0] : r2[c][DW:0];
        t_r[c]   <= {t_r[c][T-2:0], ge[c]};
      end
    end
    if (state_r == tpc_pkg::BK_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == tpc_pkg::BK_SUM) begin
      xv_r <= xv_nxt;
    end
  end

  // Pick the triangle to emit
  always_comb begin
    tri_nxt  = vtx_r;
    last_nxt = 1'b1;
    if (state_r == tpc_pkg::BK_EMIT0) begin
      tri_nxt  = {xv_r[0], vtx_r[1], vtx_r[0]};
      last_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        tpc_pkg::MODE_ONE: tri_nxt = {xv_r[1], xv_r[0], vtx_r[0]};
        tpc_pkg::MODE_TWO: tri_nxt = {xv_r[1], xv_r[0], vtx_r[1]};
        default:           tri_nxt = vtx_r;
      endcase
    end
  end

  // Output register: hold a result until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vtx   <= tri_nxt;
      out_color <= color_r;
      out_glyph <= glyph_r;
      out_last  <= last_nxt;
    end
  end

endmodule

### rtl/triangle_plane_clipper.sv
// Clips each triangle against one plane (point and inward normal, any length,
// set through the cfg_ port while idle). A vertex is inside when its distance
// is zero or more. Wholly outside triangles produce nothing, wholly inside ones
// pass unchanged, one inside gives one triangle, two inside give two (a quad);
// out_last_of_run marks the final result of each input. Input and output are
// queues: push/full and pop/empty. A two-stage distance pipeline feeds a
// four-entry queue, so input keeps flowing while results stall. The back end
// passes an unclipped triangle straight to its output register; a clipped one
// first runs the one-bit-per-cycle dividers that form the 32-bit crossing
// factors, then one multiply and one add step.
module triangle_plane_clipper #(
  parameter int COORD_BITS = tpc_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic signed [COORD_BITS-1:0]    in_vertex0_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex0_y,
  input  logic signed [COORD_BITS-1:0]    in_vertex0_z,
  input  logic signed [COORD_BITS-1:0]    in_vertex1_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex1_y,
  input  logic signed [COORD_BITS-1:0]    in_vertex1_z,
  input  logic signed [COORD_BITS-1:0]    in_vertex2_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex2_y,
  input  logic signed [COORD_BITS-1:0]    in_vertex2_z,
  input  logic [tpc_pkg::ATTR_BITS-1:0]   in_shade_color,
  input  logic [tpc_pkg::ATTR_BITS-1:0]   in_fill_glyph,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [COORD_BITS-1:0]    out_vertex0_x,
  output logic signed [COORD_BITS-1:0]    out_vertex0_y,
  output logic signed [COORD_BITS-1:0]    out_vertex0_z,
  output logic signed [COORD_BITS-1:0]    out_vertex1_x,
  output logic signed [COORD_BITS-1:0]    out_vertex1_y,
  output logic signed [COORD_BITS-1:0]    out_vertex1_z,
  output logic signed [COORD_BITS-1:0]    out_vertex2_x,
  output logic signed [COORD_BITS-1:0]    out_vertex2_y,
  output logic signed [COORD_BITS-1:0]    out_vertex2_z,
  output logic [tpc_pkg::ATTR_BITS-1:0]   out_color,
  output logic [tpc_pkg::ATTR_BITS-1:0]   out_glyph,
  output logic                            out_last_of_run,
  input  logic                            cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data
);

  localparam int C       = COORD_BITS;
  localparam int DW      = 2 * C + 3;
  localparam int ENTRY_W = 2 + 2 * tpc_pkg::ATTR_BITS + 9 * C + 3 * DW;

  logic [2:0][C-1:0]              plane_pt_r, plane_nrm_r;
  logic [2:0][2:0][C-1:0]         in_vtx, res_vtx;
  logic                           q_push, q_pop, q_empty, res_valid;
  logic [ENTRY_W-1:0]             q_wdata, q_rdata;
  logic [tpc_pkg::QCNT_W-1:0]     q_level;

  // Write plane registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_pt_r  <= {C'(tpc_pkg::POINT_Z_RST), C'(0), C'(0)};
      plane_nrm_r <= {C'(tpc_pkg::NORMAL_Z_RST), C'(0), C'(0)};
    end else if (cfg_we) begin
      unique case (tpc_pkg::cfg_idx_t'(cfg_index))
        tpc_pkg::CFG_POINT_X:  plane_pt_r[0]  <= cfg_data;
        tpc_pkg::CFG_POINT_Y:  plane_pt_r[1]  <= cfg_data;
        tpc_pkg::CFG_POINT_Z:  plane_pt_r[2]  <= cfg_data;
        tpc_pkg::CFG_NORMAL_X: plane_nrm_r[0] <= cfg_data;
        tpc_pkg::CFG_NORMAL_Y: plane_nrm_r[1] <= cfg_data;
        tpc_pkg::CFG_NORMAL_Z: plane_nrm_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_vtx = {in_vertex2_z, in_vertex2_y, in_vertex2_x,
                   in_vertex1_z, in_vertex1_y, in_vertex1_x,
                   in_vertex0_z, in_vertex0_y, in_vertex0_x};

  tpc_front #(.COORD_BITS(C)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_vtx    (in_vtx),
    .in_color  (in_shade_color),
    .in_glyph  (in_fill_glyph),
    .plane_pt  (plane_pt_r),
    .plane_nrm (plane_nrm_r),
    .q_level   (q_level),
    .q_push    (q_push),
    .q_entry   (q_wdata)
  );

  tpc_fifo #(.WIDTH(ENTRY_W), .DEPTH(tpc_pkg::QDEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .rd_en    (q_pop),
    .rd_data  (q_rdata),
    .is_empty (q_empty),
    .level    (q_level)
  );

  tpc_back #(.COORD_BITS(C)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (res_valid),
    .out_pop   (pop),
    .out_vtx   (res_vtx),
    .out_color (out_color),
    .out_glyph (out_glyph),
    .out_last  (out_last_of_run)
  );

  assign empty = !res_valid;
  assign {out_vertex2_z, out_vertex2_y, out_vertex2_x,
          out_vertex1_z, out_vertex1_y, out_vertex1_x,
          out_vertex0_z, out_vertex0_y, out_vertex0_x} = res_vtx;

  // Input credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level < tpc_pkg::QCNT_W'(tpc_pkg::QDEPTH) || q_pop))
    else $error("queue written while full");

  // Back end only takes items that are there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // Back end never pulls a new item while a result is still being formed
  a_pop_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took two items in a row");

endmodule

### tb/tb.sv
module tb;

  localparam int CB = tpc_pkg::COORD_BITS_DEF;
  localparam int AB = tpc_pkg::ATTR_BITS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_PCT = 27;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 225;
  localparam logic [tpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [tpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic signed [CB-1:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [CB-1:0] C_MIN = 32'sh80000000;

  typedef logic [2:0][CB-1:0] vtx_t;

  typedef struct packed {
    logic [2:0][2:0][CB-1:0] v;
    logic [AB-1:0] color;
    logic [AB-1:0] glyph;
  } tri_t;

  typedef struct packed {
    logic [2:0][2:0][CB-1:0] v;
    logic [AB-1:0] color;
    logic [AB-1:0] glyph;
    logic last;
  } clip_tri_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NOTHING,
    ROW_UNCHANGED
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    tri_t shape;
  } dir_row_t;

  typedef logic signed [CB-1:0] plane_t [6];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic pop = 1'b0;
  logic empty;
  logic cfg_we = 1'b0;
  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;
  logic signed [CB-1:0] in_v [9];
  logic [AB-1:0] in_shade_color = '0;
  logic [AB-1:0] in_fill_glyph = '0;
  logic signed [CB-1:0] out_v [9];
  logic [AB-1:0] out_color;
  logic [AB-1:0] out_glyph;
  logic out_last_of_run;

  logic signed [CB-1:0] plane_reg [6];
  clip_tri_t clipped_q [$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  int unsigned cycles = 0;
  dir_row_t dir_rows [$];

  initial begin
    for (int i = 0; i < 9; i++) in_v[i] = '0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  triangle_plane_clipper u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_vertex0_x(in_v[0]), .in_vertex0_y(in_v[1]), .in_vertex0_z(in_v[2]),
    .in_vertex1_x(in_v[3]), .in_vertex1_y(in_v[4]), .in_vertex1_z(in_v[5]),
    .in_vertex2_x(in_v[6]), .in_vertex2_y(in_v[7]), .in_vertex2_z(in_v[8]),
    .in_shade_color(in_shade_color), .in_fill_glyph(in_fill_glyph),
    .empty(empty), .pop(pop),
    .out_vertex0_x(out_v[0]), .out_vertex0_y(out_v[1]), .out_vertex0_z(out_v[2]),
    .out_vertex1_x(out_v[3]), .out_vertex1_y(out_v[4]), .out_vertex1_z(out_v[5]),
    .out_vertex2_x(out_v[6]), .out_vertex2_y(out_v[7]), .out_vertex2_z(out_v[8]),
    .out_color(out_color), .out_glyph(out_glyph), .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Signed distance of one vertex from the plane, exact
  function automatic logic signed [127:0] plane_dist(vtx_t p);
    logic signed [127:0] s;
    s = 0;
    for (int k = 0; k < 3; k++)
      s = s + plane_reg[3+k] * ($signed(p[k]) - plane_reg[k]);
    return s;
  endfunction

  // Edge crossing from inside vertex a to outside vertex b, saturated
  function automatic vtx_t edge_cross(vtx_t a, vtx_t b, logic signed [127:0] da,
                                      logic signed [127:0] db);
    logic signed [127:0] tf;
    logic signed [127:0] prod;
    logic signed [127:0] sum;
    vtx_t r;
    tf = (da <<< 32) / (da - db);
    for (int k = 0; k < 3; k++) begin
      prod = ($signed(b[k]) - $signed(a[k])) * tf + (128'sd1 <<< 31);
      sum = $signed(a[k]) + (prod >>> 32);
      if (sum > C_MAX) r[k] = C_MAX;
      else if (sum < C_MIN) r[k] = C_MIN;
      else r[k] = sum[CB-1:0];
    end
    return r;
  endfunction

  function automatic clip_tri_t mk_clip(vtx_t a, vtx_t b, vtx_t c, tri_t t, logic last);
    clip_tri_t r;
    r.v[0] = a;
    r.v[1] = b;
    r.v[2] = c;
    r.color = t.color;
    r.glyph = t.glyph;
    r.last = last;
    return r;
  endfunction

  // Classify the vertices and queue the clipped triangles they produce
  task automatic predict_clip(tri_t t);
    logic signed [127:0] din [3];
    logic signed [127:0] dout [3];
    logic signed [127:0] d;
    vtx_t vin [3];
    vtx_t vout [3];
    vtx_t x0;
    vtx_t x1;
    int nin;
    int nout;
    nin = 0;
    nout = 0;
    for (int i = 0; i < 3; i++) begin
      d = plane_dist(t.v[i]);
      if (d >= 0) begin
        vin[nin] = t.v[i];
        din[nin] = d;
        nin++;
      end else begin
        vout[nout] = t.v[i];
        dout[nout] = d;
        nout++;
      end
    end
    if (nin == 3) begin
      clipped_q.push_back(mk_clip(t.v[0], t.v[1], t.v[2], t, 1'b1));
    end else if (nin == 1) begin
      x0 = edge_cross(vin[0], vout[0], din[0], dout[0]);
      x1 = edge_cross(vin[0], vout[1], din[0], dout[1]);
      clipped_q.push_back(mk_clip(vin[0], x0, x1, t, 1'b1));
    end else if (nin == 2) begin
      x0 = edge_cross(vin[0], vout[0], din[0], dout[0]);
      x1 = edge_cross(vin[1], vout[0], din[1], dout[0]);
      clipped_q.push_back(mk_clip(vin[0], vin[1], x0, t, 1'b0));
      clipped_q.push_back(mk_clip(vin[1], x0, x1, t, 1'b1));
    end
  endtask

  // Offer one triangle until a transaction completes; push stays high after
  task automatic send_tri(tri_t t, row_kind_t kind);
    bit done;
    done = 1'b0;
    for (int i = 0; i < 9; i++) in_v[i] <= t.v[i/3][i%3];
    in_shade_color <= t.color;
    in_fill_glyph <= t.glyph;
    while (!done) begin
      push <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
      if (push && !full) done = 1'b1;
    end
    case (kind)
      ROW_PREDICT: predict_clip(t);
      ROW_UNCHANGED: clipped_q.push_back(mk_clip(t.v[0], t.v[1], t.v[2], t, 1'b1));
      default: ;
    endcase
  endtask

  // Drop push, wait for every result, then let the back end settle
  task automatic drain();
    push <= 1'b0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all six plane registers, optionally hitting the unused indexes too
  task automatic write_plane(plane_t pl, bit spare);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= tpc_pkg::cfg_idx_t'(i);
      cfg_data <= pl[i];
      @(posedge clk);
      plane_reg[i] = pl[i];
    end
    if (spare) begin
      cfg_index <= CFG_SPARE_LO;
      cfg_data <= $urandom;
      @(posedge clk);
      cfg_index <= CFG_SPARE_HI;
      cfg_data <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tri_t mk_tri(logic signed [CB-1:0] a0, a1, a2, b0, b1, b2,
                                  c0, c1, c2, logic [15:0] col, logic [15:0] gly);
    tri_t t;
    t.v[0] = {a2, a1, a0};
    t.v[1] = {b2, b1, b0};
    t.v[2] = {c2, c1, c0};
    t.color = col;
    t.glyph = gly;
    return t;
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    logic [CB-1:0] c;
    bit near;
    near = ($urandom_range(99) < 30);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        c = $urandom;
        if (near) c = {{11{c[20]}}, c[20:0]};
        t.v[i][k] = c;
      end
    t.color = $urandom;
    t.glyph = $urandom;
    return t;
  endfunction

  // Compare each result transaction with the oldest expected triangle
  always @(posedge clk) begin
    clip_tri_t want;
    clip_tri_t got;
    if (rst_n && pop && !empty) begin
      for (int i = 0; i < 9; i++) got.v[i/3][i%3] = out_v[i];
      got.color = out_color;
      got.glyph = out_glyph;
      got.last = out_last_of_run;
      if (clipped_q.size() == 0) begin
        $display("%0t: expected no result actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = clipped_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.v[i/3][i%3] !== want.v[i/3][i%3]) begin
            $display("%0t: vertex%0d coord%0d expected %h actual %h", $time, i/3, i%3,
                     want.v[i/3][i%3], got.v[i/3][i%3]);
            failed = 1'b1;
          end
        if (got.color !== want.color) begin
          $display("%0t: color expected %h actual %h", $time, want.color, got.color);
          failed = 1'b1;
        end
        if (got.glyph !== want.glyph) begin
          $display("%0t: glyph expected %h actual %h", $time, want.glyph, got.glyph);
          failed = 1'b1;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          failed = 1'b1;
        end
      end
    end
    pop <= rst_n && (no_idle || ($urandom_range(99) >= IDLE_PCT));
  end

  // Hold a hard bound on run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    plane_t pl;
    tri_t t;
    plane_reg[0] = '0;
    plane_reg[1] = '0;
    plane_reg[2] = tpc_pkg::POINT_Z_RST;
    plane_reg[3] = '0;
    plane_reg[4] = '0;
    plane_reg[5] = tpc_pkg::NORMAL_Z_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset plane z >= 0.1 facing +z
    dir_rows.push_back('{ROW_UNCHANGED, mk_tri(0, 0, 32'sh10000, 5, 6, 32'sh20000,
                         -7, 8, 32'sh30000, 16'h1234, 16'h00ab)});
    dir_rows.push_back('{ROW_NOTHING, mk_tri(0, 0, -32'sh10000, 5, 6, 0,
                         -7, 8, 6553, 16'hffff, 16'hffff)});
    dir_rows.push_back('{ROW_UNCHANGED, mk_tri(1, 2, 6554, 3, 4, 6554,
                         5, 6, 6554, 16'h0000, 16'h0000)});
    dir_rows.push_back('{ROW_PREDICT, mk_tri(32'sh10000, 0, 32'sh10000, 0, 32'sh10000,
                         -32'sh10000, -32'sh10000, 0, -32'sh8000, 16'h0f0f, 16'hf0f0)});
    dir_rows.push_back('{ROW_PREDICT, mk_tri(0, 0, -32'sh10000, 32'sh10000, 0,
                         32'sh10000, 0, 32'sh10000, 32'sh20000, 16'h5555, 16'haaaa)});
    dir_rows.push_back('{ROW_UNCHANGED, mk_tri(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX,
                         C_MIN, C_MIN, C_MAX, 16'hffff, 16'h0000)});
    dir_rows.push_back('{ROW_NOTHING, mk_tri(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN,
                         0, 0, C_MIN, 16'h0000, 16'hffff)});
    dir_rows.push_back('{ROW_PREDICT, mk_tri(C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN,
                         C_MIN, C_MIN, C_MIN, 16'h8001, 16'h7ffe)});
    dir_rows.push_back('{ROW_PREDICT, mk_tri(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                         C_MAX, C_MIN, C_MIN, 16'h00ff, 16'hff00)});
    foreach (dir_rows[i]) send_tri(dir_rows[i].shape, dir_rows[i].kind);
    drain();

    // Zero normal: everything passes unchanged; unused indexes must be ignored
    pl = '{C_MAX, C_MIN, 32'sd12345, 0, 0, 0};
    write_plane(pl, 1'b1);
    for (int i = 0; i < 4; i++) send_tri(rand_tri(), ROW_UNCHANGED);
    drain();

    // Extreme plane registers
    pl = '{C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN};
    write_plane(pl, 1'b0);
    for (int i = 0; i < 6; i++) send_tri(rand_tri(), ROW_PREDICT);
    drain();

    // Random phases, each with its own plane
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: pl = '{0, 0, tpc_pkg::POINT_Z_RST, 0, 0, tpc_pkg::NORMAL_Z_RST};
        1: pl = '{C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX};
        2: pl = '{$urandom_range(255), 0, 0, $urandom_range(65535) - 32768,
                  $urandom_range(65535) - 32768, $urandom_range(65535) - 32768};
        3: pl = '{0, 0, 0, 0, 0, 1};
        default: pl = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      endcase
      write_plane(pl, p == 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        no_idle = (p == 2) && (i < 150);
        send_tri(rand_tri(), ROW_PREDICT);
      end
      no_idle = 1'b0;
      drain();
    end

    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### triangle_plane_clipper.f
rtl/tpc_pkg.sv
rtl/tpc_fifo.sv
rtl/tpc_front.sv
rtl/tpc_back.sv
rtl/triangle_plane_clipper.sv
tb/tb.sv
